FILE: hdl/sha_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and a rotate function for the hash engine.
// ---------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic        store_byte;   // write pad_byte or input byte at fill_count
    logic        use_pad;      // pick the padding byte instead of input
    logic        load_vars;    // a..h <= chain hash
    logic        do_round;     // run one round
    logic        fold;         // chain += a..h
    logic        reset_chain;  // chain <= initial values, counters cleared
    logic        count_byte;   // advance total_r for a data byte; with use_pad, pick PAD_MARK
    logic        shift_out;    // rotate chain for output
  } sha_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [5:0] fill_count;
    logic [5:0] round_index;
  } sha_stat_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_SLOT  = 6'd63;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: hdl/sha_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, rolling schedule, round variables, chain hash and counters.
// ---------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  input  logic [7:0]  in_byte,
  output sha_stat_t   stat,
  output logic [31:0] chain_head
);

  logic [31:0] buf_r [16];
  logic [31:0] sched_r [16];
  logic [31:0] var_r [8];
  logic [31:0] chain_r [8];
  logic [60:0] total_r;
  logic [5:0]  fill_r;
  logic [5:0]  round_r;
  logic        wrap_r;
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic [31:0] w, x15, x2, g0, g1, s1, ch, s0, mj, t1, t2;
  logic [3:0]  slot;

  assign bits = {total_r, 3'b000};
  // Padding byte: mark at the first pad, zeros, then length bytes.
  // Hold zeros in the tail of a block whose mark already sits past the
  // length offset; the length goes into the next block.
  always_comb begin
    pad_byte = 8'h00;
    if (fill_r >= LEN_OFFSET && !wrap_r) begin
      pad_byte = bits[8'(7 - 32'(fill_r[2:0])) * 8 +: 8];
    end
  end

  assign wr_byte = cmd.use_pad ? (cmd.count_byte ? PAD_MARK : pad_byte) : in_byte;

  // Pack bytes big-endian into 32-bit buffer words.
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      buf_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  assign slot = round_r[3:0];
  assign x15  = sched_r[4'(slot + 4'd1)];
  assign x2   = sched_r[4'(slot + 4'd14)];
  assign g0   = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
  assign g1   = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);

  always_comb begin
    if (round_r < 6'd16) begin
      w = buf_r[slot];
    end else begin
      w = sched_r[slot] + g0 + sched_r[4'(slot + 4'd9)] + g1;
    end
  end

  assign s1 = ror32(var_r[4], 6) ^ ror32(var_r[4], 11) ^ ror32(var_r[4], 25);
  assign ch = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
  assign t1 = var_r[7] + s1 + ch + ROUND_K[round_r] + w;
  assign s0 = ror32(var_r[0], 2) ^ ror32(var_r[0], 13) ^ ror32(var_r[0], 22);
  assign mj = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
  assign t2 = s0 + mj;

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      var_r <= chain_r;
    end else if (cmd.do_round) begin
      sched_r[slot] <= w;
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_chain) begin
      chain_r <= INIT_HASH;
      total_r <= '0;
      fill_r  <= '0;
      round_r <= '0;
      wrap_r  <= 1'b0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + var_r[i];
        end
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) begin
          chain_r[i] <= chain_r[i + 1];
        end
        chain_r[7] <= chain_r[0];
      end
      if (cmd.store_byte) begin
        fill_r <= fill_r + 6'd1;
        if (fill_r == LAST_SLOT) begin
          wrap_r <= 1'b0;
        end else if (cmd.use_pad && cmd.count_byte && fill_r >= LEN_OFFSET) begin
          wrap_r <= 1'b1;
        end
      end
      if (cmd.count_byte && !cmd.use_pad) begin
        total_r <= total_r + 61'd1;
      end
      if (cmd.do_round) begin
        round_r <= round_r + 6'd1;
      end
    end
  end

  assign stat.fill_count  = fill_r;
  assign stat.round_index = round_r;
  assign chain_head       = chain_r[0];

endmodule

FILE: hdl/sha_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, rounds, padding and digest output.
// ---------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      in_kind,
  input  logic      out_fire,
  input  sha_stat_t stat,
  output sha_cmd_t  cmd,
  output logic      in_ready,
  output logic      out_valid,
  output logic [2:0] out_index
);

  sha_state_t state_r, state_nxt;
  logic       pad_r, pad_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pad_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pad_nxt   = pad_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.store_byte = 1'b1;
          cmd.count_byte = 1'b1;
          cmd.use_pad    = in_kind;
          pad_nxt        = in_kind;
          if (stat.fill_count == LAST_SLOT) begin
            cmd.load_vars = 1'b1;
            state_nxt     = ST_ROUND;
          end else if (in_kind) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.store_byte = 1'b1;
        cmd.use_pad    = 1'b1;
        if (stat.fill_count == LAST_SLOT) begin
          cmd.load_vars = 1'b1;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (stat.round_index == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!pad_r) begin
          state_nxt = ST_IDLE;
        // Emit only once the length field went into the block just folded.
        end else if (stat.fill_count == 6'd0 && len_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          cmd.shift_out = 1'b1;
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.shift_out   = 1'b0;
            cmd.reset_chain = 1'b1;
            pad_nxt         = 1'b0;
            state_nxt       = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Track whether the length bytes were written in the block just folded.
  always_ff @(posedge clk) begin
    if (!rst_n || state_r == ST_IDLE) begin
      len_r <= 1'b0;
    end else if (cmd.store_byte && stat.fill_count == LEN_OFFSET && pad_r) begin
      len_r <= 1'b1;
    end
  end

  assign out_index = idx_r;

endmodule

FILE: hdl/sha256_hash_engine.sv
`timescale 1ns / 1ps
// Timing: a data byte is taken and stored; a byte that fills a block then starts
//   the compression rounds (one round per cycle) and a fold into the chain hash.
// Finish: the padding bytes are written and each padded block is compressed and
//   folded, then the eight digest words follow at one per cycle as the sink takes them.
// Input: no byte is accepted while a block is compressed, padded or emitted.
// Reset: rst_n synchronous, active low; loads the initial hash, clears counts.
// ---------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with controller and datapath split.
// ---------------------------------------------------------------------------
module sha256_hash_engine import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] kind: 1 = finish
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast    // last_word
);

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [31:0] head;
  logic [2:0]  idx;
  logic        in_fire, out_fire;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_kind(in_tuser),
    .out_fire(out_fire), .stat(stat), .cmd(cmd), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_index(idx)
  );

  sha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_byte(in_tdata),
    .stat(stat), .chain_head(head)
  );

  // Hold the word at the chain head; rotate it on each taken word.
  assign out_tdata = {5'd0, idx, head};
  assign out_tlast = (idx == 3'd7);

endmodule

FILE: sim/sha256_digest_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the byte and digest streams, hashes accepted bytes itself and
// compares every digest word against its own result.
// ---------------------------------------------------------------------------
module sha256_digest_checker import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // [31:0] digest_word, [34:32] word_index
  input  logic        out_tlast,   // last_word
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic [31:0] chain [8];
  logic [7:0]  block [64];
  logic [60:0] byte_total;
  logic [5:0]  fill;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {block[4*r], block[4*r+1], block[4*r+2], block[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = w[r-16] + w[r-7]
           + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
           + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic absorb(input logic [7:0] b);
    block[fill] = b;
    fill = fill + 6'd1;
    if (fill == 0) compress();
  endtask

  task automatic finish_digest();
    logic [63:0] bits;
    digest_word_t d;
    bits = {byte_total, 3'b000};
    absorb(PAD_MARK);
    while (fill != LEN_OFFSET) absorb(8'h00);
    for (int i = 0; i < 8; i++) absorb(bits[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      d.digest_word = chain[i];
      d.word_index  = i[2:0];
      d.last_word   = (i == 7);
      digest_q.insert(digest_q.size(), d);
    end
    for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
    byte_total = '0;
    fill = '0;
  endtask

  always @(posedge clk) begin
    digest_word_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
      byte_total = '0;
      fill = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[34:32], out_tlast};
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h idx %0d", got.digest_word, got.word_index);
        end else begin
          want = digest_q.pop_front();
          if (got != want || out_tdata[39:35] != '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                       want.digest_word, want.word_index, want.last_word,
                       got.digest_word, got.word_index, got.last_word);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) finish_digest();
        else begin
          byte_total = byte_total + 61'd1;
          absorb(in_tdata);
        end
      end
    end
    words_pending = digest_q.size();
  end

endmodule

FILE: sim/sha256_hash_engine_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 hash engine test
// Feeds messages of random length and content, with random gaps and sink
// stalls, and lets the checker compare every digest word.
// ---------------------------------------------------------------------------
module sha256_hash_engine_test;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tuser;    // [0] kind: 1 = finish
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [31:0] digest_word, [34:32] word_index
  logic        out_tlast;   // last_word

  int  fail_count;
  int  words_pending;
  int  idle_cycles = 0;
  bit  quiet_phase;
  bit  timed_out = 1'b0;

  sha256_hash_engine i_dut (.*);
  sha256_digest_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sink: stall in random bursts, never in the quiet phase.
  initial begin
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Send one word and hold it until taken; gaps are random bursts.
  task automatic send_word(input logic kind, input logic [7:0] b);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Random-content message of a given length, then finish with noise byte.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_word(1'b0, 8'($urandom));
    send_word(1'b1, 8'($urandom));
  endtask

  initial begin
    int sent;
    int len;
    quiet_phase = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, finish carrying a byte, extreme bytes.
    send_word(1'b1, 8'h00);
    send_word(1'b1, 8'hff);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hff);
    send_word(1'b1, 8'h00);
    for (int i = 0; i < 3; i++) send_word(1'b0, 8'(8'h61 + i));
    send_word(1'b1, 8'h00);

    // Random: lengths around the block and padding boundaries, half of them short.
    sent = 0;
    while (sent < 210) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 57);
        1: len = $urandom_range(62, 65);
        2: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 20);
      endcase
      if (sent + len + 1 > 220) len = 220 - sent - 1;
      if (sent > 170) quiet_phase = 1'b1;
      send_message(len);
      sent += len + 1;
    end
    in_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sha_pkg.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_hash_engine.sv
sim/sha256_digest_checker.sv
sim/sha256_hash_engine_test.sv
